FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/etpc_pkg.sv
// ----------------------------------------------------------------------------
// etpc_pkg
// Types, codes and constants of the encoder turn position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etpc_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int DRIVE_BITS_DEF = 9;

  localparam int ANGLE_W    = 18;
  localparam int COUNT_W    = 32;
  localparam int ANGLE_LSB  = 0;
  localparam int LEFT_LSB   = ANGLE_LSB + ANGLE_W;
  localparam int RIGHT_LSB  = LEFT_LSB + COUNT_W;
  localparam int IN_DATA_W  = ((ANGLE_W + 2 * COUNT_W + 7) / 8) * 8;

  localparam int ELAPSED_W  = 17;
  localparam int SINCE_W    = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_COUNTS_PER_DEGREE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_TIMEOUT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_KP           = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DRIVE         = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DRIVE         = 3'd6;

  localparam logic [23:0] RST_COUNTS_PER_DEGREE = 24'd65536;
  localparam logic [7:0]  RST_SAMPLE_PERIOD     = 8'd10;
  localparam logic [15:0] RST_TURN_TIMEOUT      = 16'd5000;
  localparam logic [15:0] RST_TOLERANCE         = 16'd5;
  localparam logic [15:0] RST_GAIN_KP           = 16'd256;
  localparam logic [7:0]  RST_MIN_DRIVE         = 8'd60;
  localparam logic [7:0]  RST_MAX_DRIVE         = 8'd200;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_RUN     = 2'd0,
    STATUS_DONE    = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] tolerance_counts;
    logic [15:0] gain_kp;
    logic [7:0]  min_drive;
    logic [7:0]  max_drive;
  } drive_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/etpc_drive.sv
// ----------------------------------------------------------------------------
// etpc_drive
// Proportional drive magnitude of one wheel from its remaining error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module etpc_drive #(
  parameter int COUNT_BITS = etpc_pkg::COUNT_BITS_DEF,
  parameter int DRIVE_BITS = etpc_pkg::DRIVE_BITS_DEF
) (
  input  logic signed [COUNT_BITS:0]   err,
  input  etpc_pkg::drive_cfg_t         cfg,
  output logic                         busy,
  output logic        [DRIVE_BITS-2:0] mag
);

  localparam int LIM = 2 ** (DRIVE_BITS - 1) - 1;

  logic signed [COUNT_BITS:0]    tol_s;
  logic        [COUNT_BITS+15:0] prod;
  logic        [COUNT_BITS+7:0]  cmd;
  logic        [COUNT_BITS+7:0]  raised;
  logic        [7:0]             sel;

  assign tol_s  = $signed((COUNT_BITS + 1)'(cfg.tolerance_counts));
  assign busy   = err > tol_s;
  assign prod   = (COUNT_BITS + 16)'(err[COUNT_BITS-1:0]) * (COUNT_BITS + 16)'(cfg.gain_kp);
  assign cmd    = prod[COUNT_BITS+15:8];
  assign raised = (cmd < (COUNT_BITS + 8)'(cfg.min_drive)) ?
                  (COUNT_BITS + 8)'(cfg.min_drive) : cmd;
  assign sel    = (raised > (COUNT_BITS + 8)'(cfg.max_drive)) ? cfg.max_drive : raised[7:0];

  always_comb begin
    if (!busy) begin
      mag = '0;
    end else if (int'(sel) > LIM) begin
      mag = (DRIVE_BITS - 1)'(LIM);
    end else begin
      mag = (DRIVE_BITS - 1)'(sel);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/encoder_turn_position_controller.sv
// ----------------------------------------------------------------------------
// encoder_turn_position_controller
// Spin-in-place turn controller with proportional position control per wheel.
// ----------------------------------------------------------------------------
// Channel   Dir  Transfer carries
// s_axis    in   tuser: command; tdata: turn_angle, left encoder count, right encoder count
// m_axis    out  tdata: left_drive, right_drive, status
// cfg       in   one register write per cycle with cfg_we high
//
// One item is taken every cycle while s_axis does not stall; its result, if any,
// passes through the input register and then the result register to m_axis.
// While a result waits on m_axis, one more item is held in the input register
// and s_axis then stalls until the result is taken.
// Reset is synchronous, brings the config registers back to their defaults and clears the valid and turn flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module encoder_turn_position_controller #(
  parameter int COUNT_BITS = etpc_pkg::COUNT_BITS_DEF,
  parameter int DRIVE_BITS = etpc_pkg::DRIVE_BITS_DEF,
  localparam int OUT_RAW_W = 2 * DRIVE_BITS + 2,
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // turn_angle, left encoder count, right encoder count
  input  logic [etpc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // command
  input  logic [0:0]                           s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // left_drive, right_drive, status
  output logic [OUT_W-1:0]                     m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [etpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [etpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [31:0] TMAX = 32'((64'd1 << (COUNT_BITS - 1)) - 64'd1);
  localparam logic [etpc_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [etpc_pkg::SINCE_W-1:0]   SINCE_MAX   = '1;
  localparam logic [42:0] ROUND_HALF = 43'd8388608;

  logic [23:0] counts_per_degree;
  logic [7:0]  sample_period;
  logic [15:0] timeout_limit;
  etpc_pkg::drive_cfg_t drive_cfg;

  logic                              in_valid;
  logic                              in_cmd;
  logic [etpc_pkg::ANGLE_W-1:0]      in_angle;
  logic [COUNT_BITS-1:0]             in_left;
  logic [COUNT_BITS-1:0]             in_right;

  logic                              active, active_next;
  logic                              turn_positive, turn_positive_next;
  logic [COUNT_BITS-2:0]             target_travel, target_travel_next;
  logic [COUNT_BITS-1:0]             origin_left, origin_left_next;
  logic [COUNT_BITS-1:0]             origin_right, origin_right_next;
  logic [etpc_pkg::ELAPSED_W-1:0]    elapsed_ms, elapsed_ms_next;
  logic [etpc_pkg::SINCE_W-1:0]      since_sample_ms, since_sample_ms_next;

  logic                              advance;
  logic                              out_load;
  logic                              res_valid;
  logic signed [DRIVE_BITS-1:0]      res_left;
  logic signed [DRIVE_BITS-1:0]      res_right;
  etpc_pkg::status_t                 res_status;

  logic signed [DRIVE_BITS-1:0]      left_q;
  logic signed [DRIVE_BITS-1:0]      right_q;
  etpc_pkg::status_t                 status_q;

  logic [etpc_pkg::ANGLE_W-1:0]      angle_mag;
  logic [41:0]                       tgt_prod;
  logic [42:0]                       tgt_round;
  logic [18:0]                       tgt_full;
  logic [etpc_pkg::ELAPSED_W-1:0]    elapsed_inc;
  logic [etpc_pkg::SINCE_W-1:0]      since_inc;
  logic [COUNT_BITS-1:0]             diff_left, diff_right;
  logic [COUNT_BITS-1:0]             travel_left, travel_right;
  logic signed [COUNT_BITS:0]        err_left, err_right;
  logic                              busy_left, busy_right;
  logic [DRIVE_BITS-2:0]             mag_left, mag_right;
  logic signed [DRIVE_BITS-1:0]      pos_left, pos_right;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign out_load      = advance && res_valid;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tdata  = OUT_W'({status_q, right_q, left_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_degree          <= etpc_pkg::RST_COUNTS_PER_DEGREE;
      sample_period              <= etpc_pkg::RST_SAMPLE_PERIOD;
      timeout_limit              <= etpc_pkg::RST_TURN_TIMEOUT;
      drive_cfg.tolerance_counts <= etpc_pkg::RST_TOLERANCE;
      drive_cfg.gain_kp          <= etpc_pkg::RST_GAIN_KP;
      drive_cfg.min_drive        <= etpc_pkg::RST_MIN_DRIVE;
      drive_cfg.max_drive        <= etpc_pkg::RST_MAX_DRIVE;
    end else if (cfg_we) begin
      case (cfg_index)
        etpc_pkg::REG_COUNTS_PER_DEGREE: counts_per_degree <= cfg_data;
        etpc_pkg::REG_SAMPLE_PERIOD:     sample_period <= cfg_data[7:0];
        etpc_pkg::REG_TURN_TIMEOUT:      timeout_limit <= cfg_data[15:0];
        etpc_pkg::REG_TOLERANCE:         drive_cfg.tolerance_counts <= cfg_data[15:0];
        etpc_pkg::REG_GAIN_KP:           drive_cfg.gain_kp <= cfg_data[15:0];
        etpc_pkg::REG_MIN_DRIVE:         drive_cfg.min_drive <= cfg_data[7:0];
        etpc_pkg::REG_MAX_DRIVE:         drive_cfg.max_drive <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd   <= s_axis_tuser[0];
      in_angle <= s_axis_tdata[etpc_pkg::ANGLE_LSB +: etpc_pkg::ANGLE_W];
      in_left  <= s_axis_tdata[etpc_pkg::LEFT_LSB +: COUNT_BITS];
      in_right <= s_axis_tdata[etpc_pkg::RIGHT_LSB +: COUNT_BITS];
    end
  end

  assign angle_mag = in_angle[etpc_pkg::ANGLE_W-1] ? -in_angle : in_angle;
  assign tgt_prod  = 42'(angle_mag) * 42'(counts_per_degree);
  assign tgt_round = 43'(tgt_prod) + ROUND_HALF;
  assign tgt_full  = tgt_round[42:24];

  assign elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;
  assign since_inc   = (since_sample_ms < SINCE_MAX) ? since_sample_ms + 1'b1 : since_sample_ms;

  assign diff_left    = in_left - origin_left;
  assign diff_right   = in_right - origin_right;
  assign travel_left  = diff_left[COUNT_BITS-1] ? -diff_left : diff_left;
  assign travel_right = diff_right[COUNT_BITS-1] ? -diff_right : diff_right;
  assign err_left     = $signed({2'b00, target_travel}) - $signed({1'b0, travel_left});
  assign err_right    = $signed({2'b00, target_travel}) - $signed({1'b0, travel_right});

  etpc_drive #(
    .COUNT_BITS (COUNT_BITS),
    .DRIVE_BITS (DRIVE_BITS)
  ) u_drive_left (
    .err  (err_left),
    .cfg  (drive_cfg),
    .busy (busy_left),
    .mag  (mag_left)
  );

  etpc_drive #(
    .COUNT_BITS (COUNT_BITS),
    .DRIVE_BITS (DRIVE_BITS)
  ) u_drive_right (
    .err  (err_right),
    .cfg  (drive_cfg),
    .busy (busy_right),
    .mag  (mag_right)
  );

  assign pos_left  = $signed(DRIVE_BITS'(mag_left));
  assign pos_right = $signed(DRIVE_BITS'(mag_right));

  always_comb begin
    active_next          = active;
    turn_positive_next   = turn_positive;
    target_travel_next   = target_travel;
    origin_left_next     = origin_left;
    origin_right_next    = origin_right;
    elapsed_ms_next      = elapsed_ms;
    since_sample_ms_next = since_sample_ms;
    res_valid            = 1'b0;
    res_left             = '0;
    res_right            = '0;
    res_status           = etpc_pkg::STATUS_RUN;
    if (in_cmd == etpc_pkg::CMD_START) begin
      if (in_angle == '0) begin
        active_next = 1'b0;
        res_valid   = 1'b1;
        res_status  = etpc_pkg::STATUS_DONE;
      end else begin
        if (32'(tgt_full) > TMAX) begin
          target_travel_next = (COUNT_BITS - 1)'(TMAX);
        end else begin
          target_travel_next = (COUNT_BITS - 1)'(tgt_full);
        end
        turn_positive_next   = !in_angle[etpc_pkg::ANGLE_W-1];
        origin_left_next     = in_left;
        origin_right_next    = in_right;
        elapsed_ms_next      = '0;
        since_sample_ms_next = '0;
        active_next          = 1'b1;
      end
    end else if (active) begin
      elapsed_ms_next      = elapsed_inc;
      since_sample_ms_next = since_inc;
      if (since_inc >= sample_period) begin
        since_sample_ms_next = '0;
        res_valid            = 1'b1;
        if (elapsed_inc > etpc_pkg::ELAPSED_W'(timeout_limit)) begin
          active_next = 1'b0;
          res_status  = etpc_pkg::STATUS_TIMEOUT;
        end else if (!busy_left && !busy_right) begin
          active_next = 1'b0;
          res_status  = etpc_pkg::STATUS_DONE;
        end else if (turn_positive) begin
          res_left  = pos_left;
          res_right = -pos_right;
        end else begin
          res_left  = -pos_left;
          res_right = pos_right;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      elapsed_ms      <= '0;
      since_sample_ms <= '0;
    end else if (advance) begin
      active          <= active_next;
      elapsed_ms      <= elapsed_ms_next;
      since_sample_ms <= since_sample_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      turn_positive <= turn_positive_next;
      target_travel <= target_travel_next;
      origin_left   <= origin_left_next;
      origin_right  <= origin_right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_q   <= res_left;
      right_q  <= res_right;
      status_q <= res_status;
    end
  end

  `ASSERT_NEXT(a_run_keeps_active, clk, rst, out_load && res_status == etpc_pkg::STATUS_RUN, active, "running result without an active turn")
  `ASSERT_NEXT(a_end_goes_idle, clk, rst, out_load && res_status != etpc_pkg::STATUS_RUN, !active, "turn still active after its final result")
  `ASSERT_IMPLY(a_stop_zero_drive, clk, rst, m_axis_tvalid && status_q != etpc_pkg::STATUS_RUN, left_q == '0 && right_q == '0, "final result with nonzero drive")
  `ASSERT_IMPLY(a_opposite_signs, clk, rst, m_axis_tvalid && status_q == etpc_pkg::STATUS_RUN, !(left_q[DRIVE_BITS-1] && right_q[DRIVE_BITS-1]), "both wheels driven backward")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for encoder_turn_position_controller
// A queue-fed driver sends start and tick transfers. Each accepted transfer
// runs through a local model of the turn controller, and every drive result
// that it predicts is queued. A monitor compares each result transfer with the
// oldest queued prediction. Both sides idle at random, and the receiver also
// holds off for one long stretch. The controller settings change between
// phases, and each change waits until the block is quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int DRIVE_W     = etpc_pkg::DRIVE_BITS_DEF;
  localparam int ANGLE_W     = etpc_pkg::ANGLE_W;
  localparam int COUNT_W     = etpc_pkg::COUNT_W;
  localparam int IN_DATA_W   = etpc_pkg::IN_DATA_W;
  localparam int CFG_INDEX_W = etpc_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = etpc_pkg::CFG_DATA_W;
  localparam int OUT_W       = ((2 * DRIVE_W + 2 + 7) / 8) * 8;
  localparam int ANGLE_LIMIT = 92160;
  localparam longint TARGET_SAT = (longint'(1) << (etpc_pkg::COUNT_BITS_DEF - 1)) - 1;
  localparam int DRIVE_SAT   = (1 << (DRIVE_W - 1)) - 1;
  localparam int ELAPSED_SAT = (1 << etpc_pkg::ELAPSED_W) - 1;
  localparam int SINCE_SAT   = (1 << etpc_pkg::SINCE_W) - 1;

  typedef struct {
    logic               cmd;
    logic [ANGLE_W-1:0] angle;
    logic [COUNT_W-1:0] left_enc;
    logic [COUNT_W-1:0] right_enc;
  } turn_item_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    etpc_pkg::status_t         status;
  } drive_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // turn_angle, left encoder count, right encoder count
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  // command
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // left_drive, right_drive, status
  logic [OUT_W-1:0]       m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Local copy of the controller settings and turn state.
  int     cfg_cpd = int'(etpc_pkg::RST_COUNTS_PER_DEGREE);
  int     cfg_period = int'(etpc_pkg::RST_SAMPLE_PERIOD);
  int     cfg_timeout = int'(etpc_pkg::RST_TURN_TIMEOUT);
  int     cfg_tol = int'(etpc_pkg::RST_TOLERANCE);
  int     cfg_gain = int'(etpc_pkg::RST_GAIN_KP);
  int     cfg_min = int'(etpc_pkg::RST_MIN_DRIVE);
  int     cfg_max = int'(etpc_pkg::RST_MAX_DRIVE);
  bit     turn_active = 1'b0;
  bit     turn_positive = 1'b0;
  longint turn_target = 0;
  logic [COUNT_W-1:0] origin_left = '0;
  logic [COUNT_W-1:0] origin_right = '0;
  int     elapsed_ms = 0;
  int     since_sample_ms = 0;

  turn_item_t    pending_items[$];
  drive_result_t expected_drives[$];
  turn_item_t    live_item;
  drive_result_t predicted_drive;
  drive_result_t got_drive;
  drive_result_t want_drive;
  int            items_queued = 0;
  int            mismatch_count = 0;
  int            idle_pct = 10;
  int            send_gap = 0;
  int            recv_hold = 0;
  int            hold_requests = 0;
  int            holds_served = 0;
  logic [IN_DATA_W-1:0] item_word;

  encoder_turn_position_controller u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint wheel_travel(input logic [COUNT_W-1:0] now,
                                          input logic [COUNT_W-1:0] origin);
    logic [COUNT_W-1:0] delta;
    delta = now - origin;
    if (delta[COUNT_W-1]) begin
      return (longint'(1) << COUNT_W) - longint'({32'd0, delta});
    end
    return longint'({32'd0, delta});
  endfunction

  function automatic int wheel_drive(input longint err);
    longint level;
    if (err <= cfg_tol) begin
      return 0;
    end
    level = (err * cfg_gain) >>> 8;
    if (level < cfg_min) level = cfg_min;
    if (level > cfg_max) level = cfg_max;
    if (level > DRIVE_SAT) level = DRIVE_SAT;
    return int'(level);
  endfunction

  function automatic bit predict_turn_result(input turn_item_t it, output drive_result_t res);
    longint mag;
    longint err_l;
    longint err_r;
    int     drv_l;
    int     drv_r;
    res.left_drive = '0;
    res.right_drive = '0;
    res.status = etpc_pkg::STATUS_RUN;
    if (it.cmd == etpc_pkg::CMD_START) begin
      if (it.angle == '0) begin
        turn_active = 1'b0;
        res.status = etpc_pkg::STATUS_DONE;
        return 1'b1;
      end
      mag = longint'($signed(it.angle));
      if (mag < 0) mag = -mag;
      turn_target = (mag * cfg_cpd + (longint'(1) << 23)) >>> 24;
      if (turn_target > TARGET_SAT) turn_target = TARGET_SAT;
      turn_positive = !it.angle[ANGLE_W-1];
      origin_left = it.left_enc;
      origin_right = it.right_enc;
      elapsed_ms = 0;
      since_sample_ms = 0;
      turn_active = 1'b1;
      return 1'b0;
    end
    if (!turn_active) begin
      return 1'b0;
    end
    if (elapsed_ms < ELAPSED_SAT) elapsed_ms++;
    if (since_sample_ms < SINCE_SAT) since_sample_ms++;
    if (since_sample_ms < cfg_period) begin
      return 1'b0;
    end
    since_sample_ms = 0;
    if (elapsed_ms > cfg_timeout) begin
      turn_active = 1'b0;
      res.status = etpc_pkg::STATUS_TIMEOUT;
      return 1'b1;
    end
    err_l = turn_target - wheel_travel(it.left_enc, origin_left);
    err_r = turn_target - wheel_travel(it.right_enc, origin_right);
    if (err_l <= cfg_tol && err_r <= cfg_tol) begin
      turn_active = 1'b0;
      res.status = etpc_pkg::STATUS_DONE;
      return 1'b1;
    end
    drv_l = wheel_drive(err_l);
    drv_r = wheel_drive(err_r);
    res.left_drive = DRIVE_W'(turn_positive ? drv_l : -drv_l);
    res.right_drive = DRIVE_W'(turn_positive ? -drv_r : drv_r);
    return 1'b1;
  endfunction

  // Sender: presents queued items and predicts on every accepted transfer.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_turn_result(live_item, predicted_drive)) begin
          expected_drives.push_back(predicted_drive);
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          live_item = pending_items.pop_front();
          item_word = '0;
          item_word[etpc_pkg::ANGLE_LSB +: ANGLE_W] = live_item.angle;
          item_word[etpc_pkg::LEFT_LSB +: COUNT_W] = live_item.left_enc;
          item_word[etpc_pkg::RIGHT_LSB +: COUNT_W] = live_item.right_enc;
          s_axis_tdata <= item_word;
          s_axis_tuser <= live_item.cmd;
          s_axis_tvalid <= 1'b1;
          if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(1, 16);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_drive.left_drive = m_axis_tdata[DRIVE_W-1:0];
        got_drive.right_drive = m_axis_tdata[2*DRIVE_W-1:DRIVE_W];
        got_drive.status = etpc_pkg::status_t'(m_axis_tdata[2*DRIVE_W+1:2*DRIVE_W]);
        if (expected_drives.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result left %0d right %0d status %0d", $time,
                     got_drive.left_drive, got_drive.right_drive, got_drive.status);
          end
        end else begin
          want_drive = expected_drives.pop_front();
          if (got_drive.left_drive !== want_drive.left_drive ||
              got_drive.right_drive !== want_drive.right_drive ||
              got_drive.status !== want_drive.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: expected left %0d right %0d status %0d, got %0d %0d %0d",
                       $time, want_drive.left_drive, want_drive.right_drive,
                       want_drive.status, got_drive.left_drive, got_drive.right_drive,
                       got_drive.status);
            end
          end
        end
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        recv_hold = 300;
      end else if (recv_hold == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 4) begin
        recv_hold = $urandom_range(1, 16);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void add_item(input logic cmd, input int angle,
                                   input logic [COUNT_W-1:0] lc,
                                   input logic [COUNT_W-1:0] rc);
    turn_item_t it;
    it.cmd = cmd;
    it.angle = ANGLE_W'(angle);
    it.left_enc = lc;
    it.right_enc = rc;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    case (idx)
      etpc_pkg::REG_COUNTS_PER_DEGREE: cfg_cpd = value;
      etpc_pkg::REG_SAMPLE_PERIOD:     cfg_period = value;
      etpc_pkg::REG_TURN_TIMEOUT:      cfg_timeout = value;
      etpc_pkg::REG_TOLERANCE:         cfg_tol = value;
      etpc_pkg::REG_GAIN_KP:           cfg_gain = value;
      etpc_pkg::REG_MIN_DRIVE:         cfg_min = value;
      etpc_pkg::REG_MAX_DRIVE:         cfg_max = value;
      default: ;
    endcase
  endtask

  task automatic set_controller(input int cpd, input int period, input int timeout,
                                input int tol, input int gain, input int min_d,
                                input int max_d);
    write_reg(etpc_pkg::REG_COUNTS_PER_DEGREE, cpd);
    write_reg(etpc_pkg::REG_SAMPLE_PERIOD, period);
    write_reg(etpc_pkg::REG_TURN_TIMEOUT, timeout);
    write_reg(etpc_pkg::REG_TOLERANCE, tol);
    write_reg(etpc_pkg::REG_GAIN_KP, gain);
    write_reg(etpc_pkg::REG_MIN_DRIVE, min_d);
    write_reg(etpc_pkg::REG_MAX_DRIVE, max_d);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_drives.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // One start followed by ticks whose counts mostly move the wheels toward the target, with an occasional extra start.
  task automatic queue_turn(input int n_lo, input int n_hi);
    int     angle;
    int     n;
    int     step_max;
    int     step_l;
    int     step_r;
    longint tgt;
    logic [COUNT_W-1:0] lc;
    logic [COUNT_W-1:0] rc;
    bit     fwd_l;
    bit     fwd_r;
    if ($urandom_range(0, 3) == 0) begin
      angle = int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
    end else begin
      angle = int'($urandom_range(1, 7680));
      if ($urandom_range(0, 1) == 1) angle = -angle;
    end
    if ($urandom_range(0, 19) == 0) angle = 0;
    lc = $urandom;
    rc = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      lc = 32'h7FFF_FF00 + $urandom_range(0, 255);
      rc = 32'hFFFF_FF00 + $urandom_range(0, 255);
    end
    tgt = (longint'(angle < 0 ? -angle : angle) * cfg_cpd + (longint'(1) << 23)) >>> 24;
    n = $urandom_range(n_lo, n_hi);
    step_max = int'(2 * tgt / n) + 2;
    fwd_l = $urandom_range(0, 1);
    fwd_r = $urandom_range(0, 1);
    add_item(etpc_pkg::CMD_START, angle, lc, rc);
    repeat (n) begin
      step_l = $urandom_range(0, step_max);
      step_r = $urandom_range(0, step_max);
      if ($urandom_range(0, 9) == 0) step_l = -step_l;
      if ($urandom_range(0, 9) == 0) step_r = -step_r;
      lc = fwd_l ? lc + 32'(step_l) : lc - 32'(step_l);
      rc = fwd_r ? rc + 32'(step_r) : rc - 32'(step_r);
      if ($urandom_range(0, 39) == 0) begin
        add_item(etpc_pkg::CMD_START,
                 int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT, lc, rc);
      end
      add_item(etpc_pkg::CMD_TICK,
               int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT, lc, rc);
    end
  endtask

  task automatic queue_random(input int budget, input int n_lo, input int n_hi);
    int stop_at;
    stop_at = items_queued + budget;
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 6) == 0) begin
        add_item(logic'($urandom_range(0, 1)),
                 int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT, $urandom, $urandom);
      end else begin
        queue_turn(n_lo, n_hi);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: short sample period and timeout.
    set_controller(65536, 1, 6, 5, 256, 60, 200);
    add_item(etpc_pkg::CMD_TICK, 0, 32'h1234_5678, 32'h8765_4321);
    add_item(etpc_pkg::CMD_START, 0, 32'h0, 32'h0);
    add_item(etpc_pkg::CMD_START, ANGLE_LIMIT, 32'h7FFF_FFF0, 32'h8000_0010);
    add_item(etpc_pkg::CMD_TICK, 0, 32'h8000_0018, 32'h7FFF_FFE8);
    add_item(etpc_pkg::CMD_TICK, 0, 32'h8000_011C, 32'h7FFF_FEAD);
    add_item(etpc_pkg::CMD_TICK, 0, 32'h8000_0180, 32'h7FFF_FEAD);
    add_item(etpc_pkg::CMD_TICK, 0, 32'h0, 32'h0);
    add_item(etpc_pkg::CMD_START, -256, 32'h0, 32'h0);
    add_item(etpc_pkg::CMD_TICK, 0, 32'h0, 32'h0);
    add_item(etpc_pkg::CMD_START, -ANGLE_LIMIT, 32'hFFFF_FFFF, 32'h0);
    repeat (7) add_item(etpc_pkg::CMD_TICK, 0, 32'hFFFF_FFFF, 32'h0);
    add_item(etpc_pkg::CMD_START, 128, 32'h1234_5678, 32'hEDCB_A987);
    add_item(etpc_pkg::CMD_START, 1, 32'h1234_5678, 32'hEDCB_A987);
    add_item(etpc_pkg::CMD_TICK, 0, 32'h1234_5678, 32'hEDCB_A987);
    add_item(etpc_pkg::CMD_START, -1, 32'h0, 32'h0);
    add_item(etpc_pkg::CMD_TICK, -ANGLE_LIMIT, 32'h8000_0000, 32'h3);
    wait_drained();

    idle_pct = 25;
    set_controller(65536, 1, 400, 5, 256, 60, 200);
    queue_random(40, 5, 40);
    hold_requests++;
    queue_random(160, 5, 40);
    wait_drained();

    idle_pct = 50;
    set_controller(16777215, 3, 65535, 0, 65535, 255, 255);
    queue_random(120, 20, 80);
    wait_drained();

    idle_pct = 25;
    set_controller(0, 1, 0, 65535, 0, 0, 0);
    queue_random(40, 3, 10);
    wait_drained();

    idle_pct = 0;
    set_controller(131072, 2, 65535, 0, 0, 0, 255);
    queue_random(100, 10, 50);
    wait_drained();

    idle_pct = 25;
    set_controller(65536, 1, 50, 10, 4096, 255, 10);
    queue_random(100, 10, 70);
    wait_drained();

    set_controller(65536, 255, 65535, 5, 512, 30, 120);
    queue_turn(260, 260);
    wait_drained();

    repeat (2) begin
      set_controller($urandom_range(0, 1 << 20), $urandom_range(1, 8),
                     $urandom_range(20, 2000), $urandom_range(0, 50),
                     $urandom_range(0, 65535), $urandom_range(0, 255),
                     $urandom_range(0, 255));
      queue_random(100, 5, 60);
      wait_drained();
    end

    idle_pct = 0;
    set_controller(65536, 1, 5000, 5, 256, 60, 200);
    queue_random(100, 5, 40);
    wait_drained();

    repeat (20) @(negedge clk);
    mismatch_count += expected_drives.size();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
